// File: rtl/button_event_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// button event decoder assertion macros
// shared property forms for the core's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BUTTON_EVENT_DECODER_CORE_ASSERT_SVH
`define BUTTON_EVENT_DECODER_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define BED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button event decoder check failed");

// next-cycle implication, idle during reset
`define BED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button event decoder check failed");

`endif

// File: rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// types and constants shared by the button event decoder modules
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int LEVELS_W = 4;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int CODE_W   = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd2000;

  // event codes
  localparam logic [CODE_W-1:0] EV_BUTTON1 = 3'd0;
  localparam logic [CODE_W-1:0] EV_LONG    = 3'd1;
  localparam logic [CODE_W-1:0] EV_SHORT   = 3'd2;
  localparam logic [CODE_W-1:0] EV_BUTTON3 = 3'd3;
  localparam logic [CODE_W-1:0] EV_BUTTON4 = 3'd4;

  // one decoded event from a poll
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } evt_t;

endpackage

// File: rtl/bed_decide.sv
// ----------------------------------------------------------------------------
// bed_decide
// per-poll event decision and the button history it keeps
// ----------------------------------------------------------------------------
module bed_decide (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [bed_pkg::LEVELS_W-1:0]  levels,
  input  logic [bed_pkg::TIME_W-1:0]    now_ms,
  input  logic [bed_pkg::CFG_W-1:0]     long_press_ms,
  output bed_pkg::evt_t                 evt
);

  logic [bed_pkg::LEVELS_W-1:0] previous_levels;
  logic [bed_pkg::TIME_W-1:0]   press_start_ms;
  logic [bed_pkg::TIME_W-1:0]   press_start_ms_next;
  logic                         long_press_done;
  logic                         long_press_done_next;
  logic [bed_pkg::LEVELS_W-1:0] rise;
  logic [bed_pkg::TIME_W-1:0]   held;
  logic                         held_over;

  // edges and wrapping hold time
  assign rise      = levels & ~previous_levels;
  assign held      = now_ms - press_start_ms;
  assign held_over = held > {{(bed_pkg::TIME_W-bed_pkg::CFG_W){1'b0}}, long_press_ms};

  // fixed priority event selection and press state update
  always_comb begin
    evt                  = '0;
    press_start_ms_next  = press_start_ms;
    long_press_done_next = long_press_done;
    if (rise[0]) begin
      evt.valid = 1'b1;
      evt.code  = bed_pkg::EV_BUTTON1;
    end else if (levels[1]) begin
      if (!previous_levels[1]) begin
        press_start_ms_next  = now_ms;
        long_press_done_next = 1'b0;
      end else if (held_over && !long_press_done) begin
        evt.valid            = 1'b1;
        evt.code             = bed_pkg::EV_LONG;
        long_press_done_next = 1'b1;
      end
    end else if (previous_levels[1]) begin
      if (!long_press_done) begin
        evt.valid = 1'b1;
        evt.code  = bed_pkg::EV_SHORT;
      end
    end else if (rise[2]) begin
      evt.valid = 1'b1;
      evt.code  = bed_pkg::EV_BUTTON3;
    end else if (rise[3]) begin
      evt.valid = 1'b1;
      evt.code  = bed_pkg::EV_BUTTON4;
    end
  end

  // history update on each consumed poll
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
      press_start_ms  <= '0;
      long_press_done <= 1'b0;
    end else if (fire) begin
      previous_levels <= levels;
      press_start_ms  <= press_start_ms_next;
      long_press_done <= long_press_done_next;
    end
  end

endmodule

// File: rtl/bed_out_reg.sv
// ----------------------------------------------------------------------------
// bed_out_reg
// result register holding one event beat for the output stream
// ----------------------------------------------------------------------------
module bed_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  bed_pkg::evt_t               evt,
  input  logic                        take,
  output logic                        room,
  output logic                        valid,
  output logic [bed_pkg::CODE_W-1:0]  code
);

  // free when empty or draining this cycle
  assign room = !valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && evt.valid) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && evt.valid) begin
      code <= evt.code;
    end
  end

endmodule

// File: rtl/button_event_decoder_core.sv
// ----------------------------------------------------------------------------
// button_event_decoder_core
// button edge, short press and long press event decoder
// ----------------------------------------------------------------------------
// Each input beat is one poll of four button levels and a millisecond
// timestamp; each poll yields zero or one event beat. Polls are taken one
// per clock while the pipeline does not stall: a poll sits in the input
// register while the decision logic compares it with the stored history,
// and its event is loaded into the output register. The pipeline stalls
// only when an event waits in the output register and the sink is not
// ready. The long press threshold is written through the cfg channel,
// which is always ready, and should only change while no poll is in
// flight.
module button_event_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bed_pkg::IN_DATA_W-1:0]   s_tdata,   // button_levels[3:0], now_ms[35:4], zero pad
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bed_pkg::OUT_DATA_W-1:0]  m_tdata,   // event_code[2:0], zero pad
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bed_pkg::CFG_W-1:0]       cfg_data   // long_press_ms[15:0]
);

  logic                           in_valid;
  logic [bed_pkg::LEVELS_W-1:0]   in_levels;
  logic [bed_pkg::TIME_W-1:0]     in_now;
  logic                           advance;
  logic                           room;
  logic [bed_pkg::CFG_W-1:0]      long_press_ms;
  logic [bed_pkg::CODE_W-1:0]     out_code;
  bed_pkg::evt_t                  evt;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= bed_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid) begin
      long_press_ms <= cfg_data;
    end
  end

  // input register
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_levels <= s_tdata[bed_pkg::LEVELS_W-1:0];
      in_now    <= s_tdata[bed_pkg::LEVELS_W +: bed_pkg::TIME_W];
    end
  end

  // decision logic and history
  bed_decide u_decide (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .levels        (in_levels),
    .now_ms        (in_now),
    .long_press_ms (long_press_ms),
    .evt           (evt)
  );

  // result register
  bed_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .evt   (evt),
    .take  (m_tready),
    .room  (room),
    .valid (m_tvalid),
    .code  (out_code)
  );

  assign m_tdata = {{(bed_pkg::OUT_DATA_W-bed_pkg::CODE_W){1'b0}}, out_code};

`include "button_event_decoder_core_assert.svh"

  // event codes stay within the defined set
  `BED_ASSERT_NOW(a_code_range, m_tvalid, m_tdata[2:0] <= bed_pkg::EV_BUTTON4)
  // an empty input register always takes a beat
  `BED_ASSERT_NOW(a_empty_ready, !in_valid, s_tready)
  // a decided event shows up on the output next cycle
  `BED_ASSERT_NEXT(a_event_out, advance && evt.valid, m_tvalid && (m_tdata[2:0] == $past(evt.code)))

endmodule
